FILE: rtl/core/pwmpd_pkg.sv
// Package for the PWM period and duty setter: widths, reset values and limits,
// controller state type and the command and status structs.
// Depends on nothing; every other file of the block imports it.
package pwmpd_pkg;

   localparam int PERIOD_W = 32;
   localparam int DUTY_W   = 18;
   localparam int EXP_W    = 4;
   localparam int TOP_W    = 16;
   localparam int CMP_W    = 17;
   localparam int PROD_W   = 2 * TOP_W;
   localparam int CNT_W    = 4;

   localparam logic [EXP_W-1:0] MAX_PRESCALE   = 4'd10;
   localparam logic [TOP_W-1:0] TOP_MAX        = 16'hFFFF;
   localparam logic [EXP_W-1:0] RESET_PRESCALE = 4'd3;
   localparam logic [TOP_W-1:0] RESET_TOP      = 16'd60000;
   localparam logic [CNT_W-1:0] DIV_LAST       = 4'd15;

   localparam logic KIND_PERIOD = 1'b0;
   localparam logic KIND_DUTY   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DECIDE,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_DIV_WB,
      ST_DUTY_MUL,
      ST_DUTY_WB,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic rescale;
      logic div_init;
      logic div_step;
      logic div_wb;
      logic duty_mul;
      logic duty_wb;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic c_big;
      logic same;
      logic need_div;
      logic div_last;
   } status_type;

endpackage

FILE: rtl/core/pwmpd_intf.sv
// Channel interfaces of the PWM period and duty setter: request and response,
// each with valid, ready and its payload. Depends on pwmpd_pkg.
interface pwmpd_req_if import pwmpd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [PERIOD_W-1:0]        period_ticks;
   logic signed [DUTY_W-1:0]   duty_fraction;

   modport source (output valid, kind, period_ticks, duty_fraction, input ready);
   modport sink   (input valid, kind, period_ticks, duty_fraction, output ready);
endinterface

interface pwmpd_rsp_if import pwmpd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [EXP_W-1:0]   prescale_exponent;
   logic [TOP_W-1:0]   top_value;
   logic [CMP_W-1:0]   compare_value;

   modport source (output valid, prescale_exponent, top_value, compare_value, input ready);
   modport sink   (input valid, prescale_exponent, top_value, compare_value, output ready);
endinterface

FILE: rtl/core/pwm_period_duty_setter_core.sv
// Top level of the PWM period and duty setter: joins the controller and the
// datapath to the request and response channels.
// Depends on pwmpd_pkg, pwmpd_intf, pwmpd_ctrl and pwmpd_dpath.
//
// The request channel carries one beat per item: kind 0 sets the period from
// period_ticks, kind 1 sets the duty from the signed Q16 duty_fraction.
// Every request beat gives exactly one response beat with the prescale
// exponent, top value and compare value as they stand after the item.
// Items are worked one at a time. A duty item multiplies the top value by the
// duty fraction and writes the result back as the compare value. A period
// item halves the period up to 10 times, until it fits the top value; when
// the setting changes and the compare value needs rescaling, the 16-step
// serial divider follows.
// The response sits in an output register, so a new request is taken while
// an earlier response still waits; a stalled receiver holds the next response
// in its final state until the register frees.
// Synchronous reset gives prescale 3, top 60000 and compare 0, with no
// response pending.
module pwm_period_duty_setter_core
   import pwmpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pwmpd_req_if.sink   req_bus,
   pwmpd_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type status;

   pwmpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pwmpd_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_period_ticks      (req_bus.period_ticks),
      .req_duty_fraction     (req_bus.duty_fraction),
      .rsp_prescale_exponent (rsp_bus.prescale_exponent),
      .rsp_top_value         (rsp_bus.top_value),
      .rsp_compare_value     (rsp_bus.compare_value)
   );

endmodule

FILE: rtl/core/pwmpd_ctrl.sv
// Controller of the PWM period and duty setter: sequences one item at a time
// and owns the response valid flag. Depends on pwmpd_pkg.
module pwmpd_ctrl
   import pwmpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_kind == KIND_DUTY) ? ST_DUTY_MUL : ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (status.c_big) begin
               cmd.shift = 1'b1;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.same) begin
               state_in = ST_FINISH;
            end else begin
               cmd.rescale = 1'b1;
               state_in    = status.need_div ? ST_DIV_INIT : ST_FINISH;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DIV_WB;
            end
         end
         ST_DIV_WB: begin
            cmd.div_wb = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_DUTY_MUL: begin
            cmd.duty_mul = 1'b1;
            state_in     = ST_DUTY_WB;
         end
         ST_DUTY_WB: begin
            cmd.duty_wb = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/pwmpd_dpath.sv
// Datapath of the PWM period and duty setter: timer settings, period halving,
// shared 16x16 multiplier, restoring divider and response register.
// Depends on pwmpd_pkg.
module pwmpd_dpath
   import pwmpd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic [PERIOD_W-1:0]       req_period_ticks,
   input  logic signed [DUTY_W-1:0]  req_duty_fraction,
   output logic [EXP_W-1:0]          rsp_prescale_exponent,
   output logic [TOP_W-1:0]          rsp_top_value,
   output logic [CMP_W-1:0]          rsp_compare_value
);

   logic [EXP_W-1:0]         prescale_ff, prescale_in;
   logic [TOP_W-1:0]         top_ff, top_in;
   logic [CMP_W-1:0]         compare_ff, compare_in;
   logic [PERIOD_W-1:0]      c_ff, c_in;
   logic [EXP_W-1:0]         expo_ff, expo_in;
   logic signed [DUTY_W-1:0] duty_ff, duty_in;
   logic [PROD_W-1:0]        product_ff, product_in;
   logic [TOP_W-1:0]         divisor_ff, divisor_in;
   logic [TOP_W-1:0]         rem_ff, rem_in;
   logic [TOP_W-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [EXP_W-1:0]         out_prescale_ff, out_prescale_in;
   logic [TOP_W-1:0]         out_top_ff, out_top_in;
   logic [CMP_W-1:0]         out_compare_ff, out_compare_in;

   logic [TOP_W-1:0] c_top;
   logic             w_zero;
   logic             w_ge;
   logic [TOP_W-1:0] mul_a;
   logic [TOP_W-1:0] mul_b;
   logic [TOP_W:0]   trial;
   logic [TOP_W:0]   diff;
   logic             fits;
   logic             duty_neg;
   logic             duty_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= RESET_PRESCALE;
         top_ff      <= RESET_TOP;
         compare_ff  <= '0;
      end else begin
         prescale_ff <= prescale_in;
         top_ff      <= top_in;
         compare_ff  <= compare_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff            <= c_in;
      expo_ff         <= expo_in;
      duty_ff         <= duty_in;
      product_ff      <= product_in;
      divisor_ff      <= divisor_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      count_ff        <= count_in;
      out_prescale_ff <= out_prescale_in;
      out_top_ff      <= out_top_in;
      out_compare_ff  <= out_compare_in;
   end

   assign c_top     = c_ff[TOP_W-1:0];
   assign w_zero    = (compare_ff == '0);
   assign w_ge      = (compare_ff >= {1'b0, top_ff});
   assign duty_neg  = duty_ff[DUTY_W-1];
   assign duty_full = !duty_neg && duty_ff[TOP_W];

   assign mul_a = cmd.duty_mul ? top_ff : c_top;
   assign mul_b = cmd.duty_mul ? duty_ff[TOP_W-1:0] : compare_ff[TOP_W-1:0];

   // One restoring step; the partial remainder always stays below the divisor.
   assign trial = {rem_ff, quo_ff[TOP_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   assign status.c_big    = (c_ff > PERIOD_W'(TOP_MAX));
   assign status.same     = (expo_ff == prescale_ff) && (c_top == top_ff);
   assign status.need_div = !w_zero && !w_ge;
   assign status.div_last = (count_ff == DIV_LAST);

   always_comb begin
      prescale_in     = prescale_ff;
      top_in          = top_ff;
      compare_in      = compare_ff;
      c_in            = c_ff;
      expo_in         = expo_ff;
      duty_in         = duty_ff;
      product_in      = product_ff;
      divisor_in      = divisor_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      count_in        = count_ff;
      out_prescale_in = out_prescale_ff;
      out_top_in      = out_top_ff;
      out_compare_in  = out_compare_ff;

      if (cmd.load) begin
         c_in    = req_period_ticks;
         expo_in = '0;
         duty_in = req_duty_fraction;
      end

      if (cmd.shift) begin
         if (expo_ff == MAX_PRESCALE) begin
            c_in = PERIOD_W'(TOP_MAX);
         end else begin
            c_in    = c_ff >> 1;
            expo_in = expo_ff + 1'b1;
         end
      end

      if (cmd.rescale || cmd.duty_mul) begin
         product_in = PROD_W'(mul_a) * PROD_W'(mul_b);
      end

      if (cmd.rescale) begin
         prescale_in = expo_ff;
         top_in      = c_top;
         divisor_in  = top_ff;
         if (w_zero) begin
            compare_in = '0;
         end else if (w_ge) begin
            compare_in = {1'b0, c_top} + 1'b1;
         end
      end

      if (cmd.div_init) begin
         rem_in   = product_ff[PROD_W-1:TOP_W];
         quo_in   = product_ff[TOP_W-1:0];
         count_in = '0;
      end

      if (cmd.div_step) begin
         rem_in   = fits ? diff[TOP_W-1:0] : trial[TOP_W-1:0];
         quo_in   = {quo_ff[TOP_W-2:0], fits};
         count_in = count_ff + 1'b1;
      end

      if (cmd.div_wb) begin
         compare_in = {1'b0, quo_ff};
      end

      if (cmd.duty_wb) begin
         if (duty_neg) begin
            compare_in = '0;
         end else if (duty_full) begin
            compare_in = {1'b0, top_ff} + 1'b1;
         end else begin
            compare_in = {1'b0, product_ff[PROD_W-1:TOP_W]};
         end
      end

      if (cmd.emit) begin
         out_prescale_in = prescale_ff;
         out_top_in      = top_ff;
         out_compare_in  = compare_ff;
      end
   end

   assign rsp_prescale_exponent = out_prescale_ff;
   assign rsp_top_value         = out_top_ff;
   assign rsp_compare_value     = out_compare_ff;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for pwm_period_duty_setter_core: directed and random
// period and duty beats, each response checked against a built-in predictor.
// Depends on pwmpd_pkg, the pwmpd_req_if and pwmpd_rsp_if channels, and the core.
module tb;
   import pwmpd_pkg::*;

   typedef struct {
      logic                     kind;
      logic [PERIOD_W-1:0]      period;
      logic signed [DUTY_W-1:0] duty;
   } pwm_request_type;

   typedef struct packed {
      logic [EXP_W-1:0] expo;
      logic [TOP_W-1:0] top;
      logic [CMP_W-1:0] cmp;
   } pwm_setting_type;

   logic clock;
   logic reset;

   pwmpd_req_if req_bus ();
   pwmpd_rsp_if rsp_bus ();

   pwm_period_duty_setter_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pwm_request_type request_q[$];
   pwm_setting_type due_settings[$];

   logic [EXP_W-1:0] pred_expo;
   logic [TOP_W-1:0] pred_top;
   logic [CMP_W-1:0] pred_cmp;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int queued_count = 0;
   int accepted_count = 0;
   int response_count = 0;
   int period_count = 0;
   int duty_count = 0;
   int rescale_count = 0;
   int unchanged_count = 0;
   int error_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_PERIOD;
      req_bus.period_ticks = '0;
      req_bus.duty_fraction = '0;
      rsp_bus.ready = 1'b0;
   end

   // Works out the settings after one beat and updates the predicted state.
   function automatic pwm_setting_type next_setting(input logic kind,
                                                    input logic [PERIOD_W-1:0] period,
                                                    input logic signed [DUTY_W-1:0] duty);
      logic [PERIOD_W-1:0] c;
      int unsigned         e;
      logic [TOP_W-1:0]    old_top;
      logic [CMP_W-1:0]    old_cmp;
      logic [63:0]         prod;
      pwm_setting_type     s;
      if (kind == KIND_PERIOD) begin
         period_count++;
         c = period;
         e = 0;
         while (c > PERIOD_W'(TOP_MAX)) begin
            c = c >> 1;
            e++;
            if (e > 32'(MAX_PRESCALE)) begin
               e = 32'(MAX_PRESCALE);
               c = PERIOD_W'(TOP_MAX);
               break;
            end
         end
         if (EXP_W'(e) == pred_expo && c[TOP_W-1:0] == pred_top) begin
            unchanged_count++;
         end else begin
            old_top = pred_top;
            old_cmp = pred_cmp;
            pred_expo = EXP_W'(e);
            pred_top = c[TOP_W-1:0];
            if (old_cmp == '0) begin
               pred_cmp = '0;
            end else if (old_cmp >= {1'b0, old_top}) begin
               pred_cmp = {1'b0, c[TOP_W-1:0]} + 17'd1;
            end else begin
               rescale_count++;
               prod = 64'(c[TOP_W-1:0]) * 64'(old_cmp);
               pred_cmp = CMP_W'(prod / 64'(old_top));
            end
         end
      end else begin
         duty_count++;
         if (duty < 0) begin
            pred_cmp = '0;
         end else if (duty >= 65536) begin
            pred_cmp = {1'b0, pred_top} + 17'd1;
         end else begin
            prod = 64'(pred_top) * 64'(duty[16:0]);
            pred_cmp = prod[32:16];
         end
      end
      s.expo = pred_expo;
      s.top = pred_top;
      s.cmp = pred_cmp;
      return s;
   endfunction

   task automatic queue_request(input logic kind, input logic [PERIOD_W-1:0] period,
                                input logic signed [DUTY_W-1:0] duty);
      pwm_request_type r;
      r.kind = kind;
      r.period = period;
      r.duty = duty;
      request_q.push_back(r);
      queued_count++;
   endtask

   task automatic wait_accepted();
      while (accepted_count != queued_count) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (!req_bus.valid || req_bus.ready) begin
            if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.kind <= request_q[0].kind;
               req_bus.period_ticks <= request_q[0].period;
               req_bus.duty_fraction <= request_q[0].duty;
               request_q.delete(0);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      pwm_setting_type want;
      if (reset) begin
         pred_expo <= RESET_PRESCALE;
         pred_top <= RESET_TOP;
         pred_cmp <= '0;
         due_settings.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            due_settings.push_back(next_setting(req_bus.kind, req_bus.period_ticks,
                                                req_bus.duty_fraction));
            accepted_count++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            response_count++;
            if (due_settings.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: unexpected response beat expo=%0d top=%0d cmp=%0d",
                           rsp_bus.prescale_exponent, rsp_bus.top_value,
                           rsp_bus.compare_value);
            end else begin
               want = due_settings.pop_front();
               if (rsp_bus.prescale_exponent !== want.expo ||
                   rsp_bus.top_value !== want.top ||
                   rsp_bus.compare_value !== want.cmp) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"ERROR: response %0d expected expo=%0d top=%0d cmp=%0d,",
                               " got expo=%0d top=%0d cmp=%0d"},
                              response_count, want.expo, want.top, want.cmp,
                              rsp_bus.prescale_exponent, rsp_bus.top_value,
                              rsp_bus.compare_value);
               end
            end
         end
      end
   end

   initial begin
      logic [PERIOD_W-1:0] last_period;
      last_period = 32'd480000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 74 : 0;
         recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 18 : 0;
         if (phase == 0) begin
            queue_request(KIND_DUTY, $urandom, DUTY_W'(65536));
            queue_request(KIND_PERIOD, 32'd480000, DUTY_W'($urandom));
            queue_request(KIND_PERIOD, 32'd0, DUTY_W'($urandom));
            queue_request(KIND_DUTY, $urandom, DUTY_W'(0));
            queue_request(KIND_PERIOD, 32'd1, DUTY_W'($urandom));
            queue_request(KIND_DUTY, $urandom, DUTY_W'(65535));
            queue_request(KIND_PERIOD, 32'h0000_FFFF, DUTY_W'($urandom));
            queue_request(KIND_DUTY, $urandom, DUTY_W'(32768));
            queue_request(KIND_PERIOD, 32'h0001_0000, DUTY_W'($urandom));
            queue_request(KIND_DUTY, $urandom, DUTY_W'(-1));
            queue_request(KIND_DUTY, $urandom, DUTY_W'(1));
            queue_request(KIND_DUTY, $urandom, DUTY_W'(-131072));
            queue_request(KIND_DUTY, $urandom, DUTY_W'(131071));
            queue_request(KIND_PERIOD, 32'h03FF_FFFF, DUTY_W'($urandom));
            queue_request(KIND_PERIOD, 32'h0400_0000, DUTY_W'($urandom));
            queue_request(KIND_PERIOD, 32'hFFFF_FFFF, DUTY_W'($urandom));
            queue_request(KIND_DUTY, $urandom, DUTY_W'(49152));
            queue_request(KIND_PERIOD, 32'd100000, DUTY_W'($urandom));
            queue_request(KIND_DUTY, $urandom, DUTY_W'(65536));
            queue_request(KIND_PERIOD, 32'h07FF_FFFF, DUTY_W'($urandom));
            queue_request(KIND_PERIOD, 32'd0, DUTY_W'($urandom));
            queue_request(KIND_DUTY, $urandom, DUTY_W'(65536));
            queue_request(KIND_PERIOD, 32'd12345, DUTY_W'($urandom));
            queue_request(KIND_DUTY, $urandom, DUTY_W'(16384));
            queue_request(KIND_PERIOD, 32'd12345, DUTY_W'($urandom));
         end
         for (int i = 0; i < 150; i++) begin
            if ($urandom_range(0, 1) == 1) begin
               if ($urandom_range(0, 3) == 0)
                  queue_request(KIND_DUTY, $urandom, DUTY_W'($urandom));
               else
                  queue_request(KIND_DUTY, $urandom, DUTY_W'($urandom_range(0, 65536)));
            end else begin
               case ($urandom_range(0, 7))
                  0: ;
                  1: last_period = $urandom;
                  default: last_period = $urandom >> $urandom_range(0, 31);
               endcase
               queue_request(KIND_PERIOD, last_period, DUTY_W'($urandom));
            end
         end
         wait_accepted();
      end

      while (due_settings.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (due_settings.size() != 0) error_count++;

      $display("Checked %0d responses over %0d period and %0d duty beats.",
               response_count, period_count, duty_count);
      $display({"Compare value divided on %0d period changes;",
                " %0d periods left settings as they were."},
               rescale_count, unchanged_count);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d of %0d beats accepted and %0d responses still due.",
               accepted_count, queued_count, due_settings.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: pwm_period_duty_setter_core.f
rtl/core/pwmpd_pkg.sv
rtl/core/pwmpd_intf.sv
rtl/core/pwmpd_ctrl.sv
rtl/core/pwmpd_dpath.sv
rtl/core/pwm_period_duty_setter_core.sv
tb/sv/tb.sv
